[rtl/psc_pkg.sv]
// Shared types and constants of the pulse serial controller responder.
package psc_pkg;

  typedef logic [14:0] ticks_t;
  typedef logic [23:0] status_t;
  typedef logic [31:0] word_t;
  typedef logic [1:0]  dur_t;
  typedef logic [0:0]  reg_idx_t;

  localparam reg_idx_t REG_THRESHOLD = 1'b0;
  localparam reg_idx_t REG_STATUS    = 1'b1;

  localparam ticks_t  THRESHOLD_RESET = 15'd100;
  localparam status_t STATUS_RESET    = 24'h050001;

  localparam logic [7:0] CMD_STATUS = 8'h00;
  localparam logic [7:0] CMD_READ   = 8'h01;

  localparam logic [3:0] CMD_PULSES = 4'd8;

  localparam logic [4:0] STATUS_LAST_BIT = 5'd23;
  localparam logic [4:0] WORD_LAST_BIT   = 5'd31;

  // Line encodings of the transmit items.
  localparam dur_t ONE_LOW   = 2'd1;
  localparam dur_t ONE_HIGH  = 2'd3;
  localparam dur_t ZERO_LOW  = 2'd3;
  localparam dur_t ZERO_HIGH = 2'd1;
  localparam dur_t STOP_LOW  = 2'd1;
  localparam dur_t STOP_HIGH = 2'd2;

  typedef enum logic [1:0] {
    KIND_BIT   = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_CLOSE = 2'd2
  } item_kind_t;

  typedef struct packed {
    logic       pulse_en;
    logic       word_en;
    logic       reply_start;
    logic       shift_en;
    item_kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic reply_due;
    logic last_bit;
  } dp_status_t;

endpackage

[rtl/psc_in_if.sv]
// Input channel: received pulses and controller word loads.
interface psc_in_if import psc_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   op;
  ticks_t low_ticks;
  logic   first_of_frame;
  word_t  controller_word;

  modport source (output valid, output op, output low_ticks, output first_of_frame,
                  output controller_word, input ready);
  modport sink (input valid, input op, input low_ticks, input first_of_frame,
                input controller_word, output ready);
endinterface

[rtl/psc_out_if.sv]
// Result channel: transmit items of a reply.
interface psc_out_if import psc_pkg::*; ();
  logic valid;
  logic ready;
  dur_t low_time;
  dur_t high_time;
  logic first_level;
  logic second_level;
  logic last;

  modport source (output valid, output low_time, output high_time, output first_level,
                  output second_level, output last, input ready);
  modport sink (input valid, input low_time, input high_time, input first_level,
                input second_level, input last, output ready);
endinterface

[rtl/pulse_serial_controller_responder.sv]
// The first reply item is offered in the cycle after the eighth pulse of a status or read
// frame is taken. A reply is 26 items (status) or 34 (controller word), one per cycle
// while out_ready is high; the reply shifter sends one bit a cycle and no transaction is
// taken during a reply. Any other transaction is taken whenever the controller is idle.
// Reset (rst_n, synchronous, active low): threshold 100, status 0x050001, frame and
// controller word cleared, no reply in progress.
module pulse_serial_controller_responder import psc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  psc_in_if.sink    in_chan,
  psc_out_if.source out_chan,
  input  logic      cfg_we,
  input  reg_idx_t  cfg_index,
  input  status_t   cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  psc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_op     (in_chan.op),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  psc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .low_ticks       (in_chan.low_ticks),
    .first_of_frame  (in_chan.first_of_frame),
    .controller_word (in_chan.controller_word),
    .cmd             (cmd),
    .status          (status),
    .low_time        (out_chan.low_time),
    .high_time       (out_chan.high_time),
    .first_level     (out_chan.first_level),
    .second_level    (out_chan.second_level),
    .last            (out_chan.last)
  );

endmodule

[rtl/psc_ctrl.sv]
// Controller state machine: takes transactions and sequences the reply items.
module psc_ctrl import psc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_op,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DATA = 4'b0010,
    S_STOP = 4'b0100,
    S_END  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r != S_IDLE);
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    cmd.pulse_en    = in_fire && !in_op;
    cmd.word_en     = in_fire && in_op;
    cmd.reply_start = in_fire && !in_op && status.reply_due;
    cmd.shift_en    = (state_r == S_DATA) && out_ready;
    case (state_r)
      S_STOP:  cmd.kind = KIND_STOP;
      S_END:   cmd.kind = KIND_CLOSE;
      default: cmd.kind = KIND_BIT;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.reply_start) state_nxt = S_DATA;
      end
      S_DATA: begin
        if (out_ready && status.last_bit) state_nxt = S_STOP;
      end
      S_STOP: begin
        if (out_ready) state_nxt = S_END;
      end
      S_END: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/psc_dp.sv]
// Datapath: configuration, command decoding registers and the reply shifter.
module psc_dp import psc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  reg_idx_t   cfg_index,
  input  status_t    cfg_wdata,
  input  ticks_t     low_ticks,
  input  logic       first_of_frame,
  input  word_t      controller_word,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output dur_t       low_time,
  output dur_t       high_time,
  output logic       first_level,
  output logic       second_level,
  output logic       last
);

  ticks_t     threshold_r;
  status_t    status_word_r;
  word_t      stored_r;
  logic [3:0] pulse_cnt_r;
  logic [7:0] cmd_shift_r;
  word_t      reply_r;
  logic [4:0] bit_cnt_r;

  logic [3:0] cnt_eff;
  logic [7:0] sh_eff;
  logic       frame_open;
  logic [7:0] sh_nxt;
  logic [3:0] cnt_nxt;

  // A frame start clears the frame before the pulse is taken in.
  assign cnt_eff    = first_of_frame ? 4'd0 : pulse_cnt_r;
  assign sh_eff     = first_of_frame ? 8'd0 : cmd_shift_r;
  assign frame_open = (cnt_eff < CMD_PULSES);
  assign sh_nxt     = {sh_eff[6:0], (low_ticks < threshold_r)};
  assign cnt_nxt    = cnt_eff + 4'd1;

  assign status.reply_due = frame_open && (cnt_nxt == CMD_PULSES) &&
                            ((sh_nxt == CMD_STATUS) || (sh_nxt == CMD_READ));
  assign status.last_bit  = (bit_cnt_r == 5'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= THRESHOLD_RESET;
      status_word_r <= STATUS_RESET;
      stored_r      <= '0;
      pulse_cnt_r   <= '0;
      cmd_shift_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: threshold_r   <= cfg_wdata[14:0];
          REG_STATUS:    status_word_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.word_en) stored_r <= controller_word;
      if (cmd.pulse_en && frame_open) begin
        pulse_cnt_r <= cnt_nxt;
        cmd_shift_r <= sh_nxt;
      end else if (cmd.pulse_en) begin
        pulse_cnt_r <= cnt_eff;
        cmd_shift_r <= sh_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reply_start) begin
      if (sh_nxt == CMD_READ) begin
        reply_r   <= stored_r;
        bit_cnt_r <= WORD_LAST_BIT;
      end else begin
        reply_r   <= {status_word_r, 8'd0};
        bit_cnt_r <= STATUS_LAST_BIT;
      end
    end else if (cmd.shift_en) begin
      reply_r   <= {reply_r[30:0], 1'b0};
      bit_cnt_r <= bit_cnt_r - 5'd1;
    end
  end

  always_comb begin
    case (cmd.kind)
      KIND_STOP: begin
        low_time = STOP_LOW;  high_time = STOP_HIGH;
        first_level = 1'b0;   second_level = 1'b1; last = 1'b0;
      end
      KIND_CLOSE: begin
        low_time = 2'd0;      high_time = 2'd0;
        first_level = 1'b1;   second_level = 1'b0; last = 1'b1;
      end
      default: begin
        low_time  = reply_r[31] ? ONE_LOW  : ZERO_LOW;
        high_time = reply_r[31] ? ONE_HIGH : ZERO_HIGH;
        first_level = 1'b0;   second_level = 1'b1; last = 1'b0;
      end
    endcase
  end

endmodule

[tb/tb_pulse_serial_controller_responder.sv]
// Self-checking testbench for the pulse serial controller responder.
`timescale 1ns / 1ps

module tb_pulse_serial_controller_responder;
  import psc_pkg::*;

  localparam logic OP_PULSE = 1'b0;
  localparam logic OP_LOAD  = 1'b1;
  localparam int   TICKS_MAX = 32767;
  localparam dur_t END_LOW  = 2'd0;
  localparam dur_t END_HIGH = 2'd0;
  localparam int   PHASES   = 6;
  localparam int   PHASE_ITEMS = 80;

  typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_EVERY_FOURTH, RDY_COIN} ready_style_t;

  typedef struct {
    logic   op;
    ticks_t low_ticks;
    logic   first_of_frame;
    word_t  controller_word;
  } rx_txn_t;

  typedef struct {
    dur_t low_time;
    dur_t high_time;
    logic first_level;
    logic second_level;
    logic last;
  } line_item_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     cfg_we;
  reg_idx_t cfg_index;
  status_t  cfg_wdata;

  psc_in_if  in_chan();
  psc_out_if out_chan();

  pulse_serial_controller_responder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  rx_txn_t    pending_q[$];
  line_item_t reply_q[$];

  // Predictor copy of the registers and the frame state.
  ticks_t     thr_reg;
  status_t    status_reg;
  logic [3:0] frame_pulses;
  logic [7:0] frame_cmd;
  word_t      held_word;

  int errors = 0;
  int pulses_seen = 0;
  int loads_seen = 0;
  int status_replies = 0;
  int word_replies = 0;
  int items_checked = 0;
  int gap_left = 0;
  int burst_left = 1;
  int stall_cnt = 0;
  ready_style_t stall_mode = RDY_ALWAYS;

  always #4 clk = ~clk;

  task automatic queue_reply(input word_t data, input int nbits);
    line_item_t it;
    for (int b = nbits - 1; b >= 0; b--) begin
      if (data[b]) begin
        it = '{ONE_LOW, ONE_HIGH, 1'b0, 1'b1, 1'b0};
      end else begin
        it = '{ZERO_LOW, ZERO_HIGH, 1'b0, 1'b1, 1'b0};
      end
      reply_q.push_back(it);
    end
    reply_q.push_back('{STOP_LOW, STOP_HIGH, 1'b0, 1'b1, 1'b0});
    reply_q.push_back('{END_LOW, END_HIGH, 1'b1, 1'b0, 1'b1});
  endtask

  task automatic predict_pulse(input ticks_t ticks, input logic first_flag);
    logic one_bit;
    if (first_flag) begin
      frame_pulses = '0;
      frame_cmd = '0;
    end
    if (frame_pulses >= CMD_PULSES) return;
    one_bit = (ticks < thr_reg);
    frame_cmd = {frame_cmd[6:0], one_bit};
    frame_pulses++;
    if (frame_pulses == CMD_PULSES) begin
      if (frame_cmd == CMD_STATUS) begin
        queue_reply({8'h00, status_reg}, 24);
        status_replies++;
      end else if (frame_cmd == CMD_READ) begin
        queue_reply(held_word, 32);
        word_replies++;
      end
    end
  endtask

  // Prediction on accepted transactions and checking of transmit items.
  always @(posedge clk) begin : track
    line_item_t want;
    if (!rst_n) begin
      thr_reg = THRESHOLD_RESET;
      status_reg = STATUS_RESET;
      frame_pulses = '0;
      frame_cmd = '0;
      held_word = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_THRESHOLD) thr_reg = cfg_wdata[14:0];
        else status_reg = cfg_wdata;
      end
      if (in_chan.valid && in_chan.ready) begin
        void'(pending_q.pop_front());
        if (in_chan.op == OP_LOAD) begin
          held_word = in_chan.controller_word;
          loads_seen++;
        end else begin
          predict_pulse(in_chan.low_ticks, in_chan.first_of_frame);
          pulses_seen++;
        end
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (out_chan.valid && out_chan.ready) begin
        items_checked++;
        if (reply_q.size() == 0) begin
          $error("transmit item arrived with no reply pending");
          errors++;
        end else begin
          want = reply_q.pop_front();
          if (out_chan.low_time !== want.low_time) begin
            $error("low_time: expected %0d, got %0d", want.low_time, out_chan.low_time);
            errors++;
          end
          if (out_chan.high_time !== want.high_time) begin
            $error("high_time: expected %0d, got %0d", want.high_time, out_chan.high_time);
            errors++;
          end
          if (out_chan.first_level !== want.first_level) begin
            $error("first_level: expected %0d, got %0d", want.first_level,
                   out_chan.first_level);
            errors++;
          end
          if (out_chan.second_level !== want.second_level) begin
            $error("second_level: expected %0d, got %0d", want.second_level,
                   out_chan.second_level);
            errors++;
          end
          if (out_chan.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_chan.last);
            errors++;
          end
        end
      end
    end
  end

  // Sender: bursts of transactions separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      in_chan.valid <= 1'b0;
    end else if (pending_q.size() != 0) begin
      in_chan.valid <= 1'b1;
      in_chan.op <= pending_q[0].op;
      in_chan.low_ticks <= pending_q[0].low_ticks;
      in_chan.first_of_frame <= pending_q[0].first_of_frame;
      in_chan.controller_word <= pending_q[0].controller_word;
    end else begin
      in_chan.valid <= 1'b0;
    end
  end

  // Receiver: drives out_ready in a stall style that is redrawn at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      stall_cnt++;
      if (stall_cnt % 97 == 0) stall_mode = ready_style_t'($urandom_range(0, 3));
      case (stall_mode)
        RDY_ALWAYS:       out_chan.ready <= 1'b1;
        RDY_MOSTLY:       out_chan.ready <= ($urandom_range(0, 3) != 0);
        RDY_EVERY_FOURTH: out_chan.ready <= (stall_cnt % 4 == 0);
        default:          out_chan.ready <= $urandom_range(0, 1);
      endcase
    end
  end

  task automatic add_pulse(input ticks_t ticks, input logic first_flag);
    pending_q.push_back('{OP_PULSE, ticks, first_flag, word_t'($urandom)});
  endtask

  task automatic add_load(input word_t data);
    pending_q.push_back('{OP_LOAD, ticks_t'($urandom_range(0, TICKS_MAX)),
                          logic'($urandom_range(0, 1)), data});
  endtask

  // Picks a low time that decodes to the wanted bit under the current threshold, landing
  // on the boundary now and then; with a zero threshold no time decodes to one, so a zero comes.
  function automatic ticks_t ticks_for(input logic bit_val);
    int lim;
    lim = thr_reg;
    if (bit_val && lim > 0) begin
      if ($urandom_range(0, 9) == 0) return ticks_t'(lim - 1);
      return ticks_t'($urandom_range(0, lim - 1));
    end
    if (!bit_val && $urandom_range(0, 9) == 0) return ticks_t'(lim);
    return ticks_t'($urandom_range(lim, TICKS_MAX));
  endfunction

  task automatic add_frame(input logic [7:0] cmd, input int n, input logic with_load);
    int mid;
    mid = $urandom_range(1, 7);
    for (int i = 0; i < n; i++) begin
      if (with_load && i == mid) add_load($urandom);
      add_pulse(ticks_for(cmd[7 - i]), i == 0);
    end
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || reply_q.size() != 0 || in_chan.valid)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input status_t data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int made;
    int pick;
    int n;
    logic [7:0] cmd;
    ticks_t  thr_plan[PHASES];
    status_t status_plan[PHASES];

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.op = OP_PULSE;
    in_chan.low_ticks = '0;
    in_chan.first_of_frame = 1'b0;
    in_chan.controller_word = '0;
    out_chan.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // A frame right after reset without the frame-start flag decodes as status.
    add_pulse(15'd100, 1'b0);
    add_pulse(ticks_t'(TICKS_MAX), 1'b0);
    for (int i = 0; i < 6; i++) add_pulse(ticks_for(1'b0), 1'b0);
    add_load(32'hA5C3_0F81);
    // Read command with a load in the middle of the frame; the reply uses the later word.
    add_pulse(ticks_t'(TICKS_MAX), 1'b1);
    for (int i = 0; i < 3; i++) add_pulse(15'd100, 1'b0);
    pending_q.push_back('{OP_LOAD, ticks_t'(TICKS_MAX), 1'b1, 32'h5A3C_F07E});
    for (int i = 0; i < 3; i++) add_pulse(ticks_for(1'b0), 1'b0);
    add_pulse(15'd99, 1'b0);
    // A ninth pulse is ignored, then a short frame gets no reply.
    add_pulse(15'd0, 1'b0);
    add_pulse(15'd0, 1'b1);
    add_pulse(15'd0, 1'b0);
    add_pulse(ticks_t'(TICKS_MAX), 1'b0);
    wait_idle();

    thr_plan = '{15'd0, 15'd32767, ticks_t'($urandom_range(1, 2000)), 15'd1,
                 ticks_t'($urandom_range(0, TICKS_MAX)), THRESHOLD_RESET};
    status_plan = '{24'hFFFFFF, 24'h000000, status_t'($urandom), status_t'($urandom),
                    status_t'($urandom), STATUS_RESET};

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_THRESHOLD, {9'd0, thr_plan[p]});
      write_reg(REG_STATUS, status_plan[p]);
      made = 0;
      while (made < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          n = $urandom_range(0, 99);
          cmd = (n < 45) ? CMD_STATUS : (n < 85) ? CMD_READ : 8'($urandom);
          add_frame(cmd, 8, $urandom_range(0, 9) == 0);
          made += 8;
          if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) add_pulse(ticks_t'($urandom_range(0, TICKS_MAX)), 1'b0);
          end
        end else if (pick < 80) begin
          add_load($urandom);
          made++;
        end else if (pick < 90) begin
          n = $urandom_range(1, 7);
          add_frame(8'($urandom), n, 1'b0);
          made += n;
        end else begin
          repeat ($urandom_range(1, 4)) begin
            add_pulse(ticks_t'($urandom_range(0, TICKS_MAX)), logic'($urandom_range(0, 1)));
            made++;
          end
        end
      end
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (reply_q.size() != 0) begin
      $error("%0d transmit items never arrived", reply_q.size());
      errors++;
    end
    $display("Sent %0d pulses and %0d controller word loads across %0d register settings.",
             pulses_seen, loads_seen, PHASES + 1);
    $display("Checked %0d transmit items from %0d status and %0d controller word replies.",
             items_checked, status_replies, word_replies);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
